### rtl/core/adpf_pkg.sv
`timescale 1ns / 1ps

package adpf_pkg;

  localparam int unsigned CountW = 10;
  localparam logic [CountW-1:0] CountMax = 10'd1023;
  localparam logic [CountW-1:0] HdrLen = 10'd18;
  localparam logic [10:0] MinLen = 11'd10;

  localparam logic [15:0] OpPoll = 16'h2000;
  localparam logic [15:0] OpPollReply = 16'h2100;
  localparam logic [15:0] OpDmx = 16'h5000;

  localparam logic [1:0] CfgFilterOn = 2'd0;
  localparam logic [1:0] CfgFilterAddr = 2'd1;
  localparam logic [1:0] CfgOutputEnable = 2'd2;

  typedef enum logic [2:0] {
    KIND_IGNORED    = 3'd0,
    KIND_POLL       = 3'd1,
    KIND_POLL_REPLY = 3'd2,
    KIND_DMX_OK     = 3'd3,
    KIND_OTHER_UNIV = 3'd4,
    KIND_LEN_BAD    = 3'd5,
    KIND_UNKNOWN_OP = 3'd6
  } kind_e;

  typedef struct packed {
    logic        source_filter_on;
    logic [31:0] source_filter_address;
    logic        output_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        end_of_packet;
    logic        rx_error;
    logic [31:0] source_address;
  } item_t;

  typedef struct packed {
    logic        data_valid;
    logic [8:0]  channel_index;
    logic [7:0]  channel_value;
    logic        packet_done;
    kind_e       packet_kind;
    logic        dmx_commit;
  } result_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] art_id(input logic [2:0] pos);
    logic [7:0] v;
    unique case (pos)
      3'd0: v = 8'h41;
      3'd1: v = 8'h72;
      3'd2: v = 8'h74;
      3'd3: v = 8'h2D;
      3'd4: v = 8'h4E;
      3'd5: v = 8'h65;
      3'd6: v = 8'h74;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/adpf_parser.sv
`timescale 1ns / 1ps

module adpf_parser #(
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  adpf_pkg::cfg_t    cfg_i,
  input  adpf_pkg::item_t   item_i,
  output adpf_pkg::result_t res_o
);
  import adpf_pkg::*;

  localparam logic [CountW-1:0] ChLimit = CountW'(MAX_CHANNELS);

  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic              id_ok_q, id_ok_d;
  logic [15:0]       opcode_q, opcode_d;
  logic              univ_nz_q, univ_nz_d;
  logic [15:0]       length_q, length_d;
  logic              src_ok_q, src_ok_d;
  logic              over_q, over_d;

  logic [CountW-1:0] idx;
  logic [7:0]        b;
  logic              id_ok_n, univ_nz_n, src_ok_n, over_n, over_hit, in_hdr, dmx_op;
  logic [15:0]       opcode_n, length_n;
  logic [CountW-1:0] ch_full;
  logic [10:0]       size;
  logic [16:0]       len_plus;
  logic              len_match;
  kind_e             kind;

  assign idx = byte_count_q;
  assign b   = item_i.payload_byte;

  always_comb begin
    src_ok_n  = src_ok_q;
    id_ok_n   = id_ok_q;
    opcode_n  = opcode_q;
    univ_nz_n = univ_nz_q;
    length_n  = length_q;
    if (idx == '0) begin
      src_ok_n = !cfg_i.source_filter_on ||
                 (item_i.source_address == cfg_i.source_filter_address);
    end
    if (idx < 10'd8) begin
      if (b != art_id(idx[2:0])) id_ok_n = 1'b0;
    end else if (idx == 10'd8) begin
      opcode_n = {opcode_q[15:8], b};
    end else if (idx == 10'd9) begin
      opcode_n = {b, opcode_q[7:0]};
    end else if (idx == 10'd14 || idx == 10'd15) begin
      if (b != 8'h00) univ_nz_n = 1'b1;
    end else if (idx == 10'd16) begin
      length_n = {b, length_q[7:0]};
    end else if (idx == 10'd17) begin
      length_n = {length_q[15:8], b};
    end
  end

  assign in_hdr   = idx >= HdrLen;
  assign ch_full  = idx - HdrLen;
  assign over_hit = in_hdr && (ch_full >= ChLimit);
  assign over_n   = over_q | over_hit;
  assign dmx_op   = opcode_n == OpDmx;

  assign size      = {1'b0, idx} + 11'd1;
  assign len_plus  = {1'b0, length_n} + 17'(HdrLen);
  assign len_match = {6'b0, size} == len_plus;

  always_comb begin
    if (item_i.rx_error || size < MinLen || !id_ok_n || !src_ok_n) begin
      kind = KIND_IGNORED;
    end else if (opcode_n == OpPoll) begin
      kind = KIND_POLL;
    end else if (opcode_n == OpPollReply) begin
      kind = KIND_POLL_REPLY;
    end else if (dmx_op) begin
      if (univ_nz_n) kind = KIND_OTHER_UNIV;
      else if (over_n || !len_match) kind = KIND_LEN_BAD;
      else kind = KIND_DMX_OK;
    end else begin
      kind = KIND_UNKNOWN_OP;
    end
  end

  always_comb begin
    res_o.data_valid    = in_hdr && !over_hit && id_ok_n && src_ok_n && dmx_op && !univ_nz_n;
    res_o.channel_index = res_o.data_valid ? ch_full[8:0] : 9'd0;
    res_o.channel_value = res_o.data_valid ? b : 8'd0;
    res_o.packet_done   = item_i.end_of_packet;
    res_o.packet_kind   = item_i.end_of_packet ? kind : KIND_IGNORED;
    res_o.dmx_commit    = item_i.end_of_packet && (kind == KIND_DMX_OK) && cfg_i.output_enable;
  end

  always_comb begin
    if (item_i.end_of_packet) begin
      byte_count_d = '0;
      id_ok_d      = 1'b1;
      opcode_d     = '0;
      univ_nz_d    = 1'b0;
      length_d     = '0;
      src_ok_d     = 1'b0;
      over_d       = 1'b0;
    end else begin
      byte_count_d = (idx < CountMax) ? idx + 10'd1 : idx;
      id_ok_d      = id_ok_n;
      opcode_d     = opcode_n;
      univ_nz_d    = univ_nz_n;
      length_d     = length_n;
      src_ok_d     = src_ok_n;
      over_d       = over_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      id_ok_q      <= 1'b1;
      opcode_q     <= '0;
      univ_nz_q    <= 1'b0;
      length_q     <= '0;
      src_ok_q     <= 1'b0;
      over_q       <= 1'b0;
    end else if (en_i) begin
      byte_count_q <= byte_count_d;
      id_ok_q      <= id_ok_d;
      opcode_q     <= opcode_d;
      univ_nz_q    <= univ_nz_d;
      length_q     <= length_d;
      src_ok_q     <= src_ok_d;
      over_q       <= over_d;
    end
  end

endmodule

### rtl/core/artnet_dmx_packet_filter.sv
`timescale 1ns / 1ps

// Art-Net receive filter: takes one UDP payload byte per item and returns one result
// item per byte, carrying the DMX channel level and index for bytes of a candidate
// ArtDmx frame and, on the last byte, the packet kind and the commit flag. One item is
// taken every clock cycle while the output does not stall; each byte is held in the
// input register and then passes through the header parser into the result register.
// The parser keeps a running byte counter and captured header fields, which it updates
// once per byte. Source filtering and output enable must be set over the config port
// only while no packet is in flight; the block itself does not enforce this.
module artnet_dmx_packet_filter #(
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // payload_byte, source_address
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,   // rx_error
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // data_valid, channel_index, channel_value, zero pad
  output logic        m_axis_tlast_o,
  output logic [3:0]  m_axis_tuser_o,   // packet_kind, dmx_commit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import adpf_pkg::*;

  cfg_t    cfg_q;
  item_t   s1_item_q;
  logic    s1_valid_q, s1_valid_d;
  result_t out_q, res;
  logic    out_valid_q, out_valid_d;
  logic    accept, advance;

  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_valid_d      = accept || (s1_valid_q && !advance);
  assign out_valid_d     = advance || (out_valid_q && !m_axis_tready_i);
  assign cfg_ready_o     = 1'b1;

  adpf_parser #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .cfg_i (cfg_q),
    .item_i(s1_item_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_filter_on      <= 1'b0;
      cfg_q.source_filter_address <= '0;
      cfg_q.output_enable         <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFilterOn:     cfg_q.source_filter_on      <= cfg_data_i[0];
        CfgFilterAddr:   cfg_q.source_filter_address <= cfg_data_i;
        CfgOutputEnable: cfg_q.output_enable         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.payload_byte   <= s_axis_tdata_i[7:0];
      s1_item_q.source_address <= s_axis_tdata_i[39:8];
      s1_item_q.end_of_packet  <= s_axis_tlast_i;
      s1_item_q.rx_error       <= s_axis_tuser_i;
    end
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.channel_value, out_q.channel_index, out_q.data_valid};
  assign m_axis_tlast_o  = out_q.packet_done;
  assign m_axis_tuser_o  = {out_q.dmx_commit, out_q.packet_kind};

endmodule
